### rtl/core/tsw_pkg.sv
// ----------------------------------------------------------------------------
// tsw_pkg
// Widths and fixed-point constants shared by the Taylor sine core.
// ----------------------------------------------------------------------------
package tsw_pkg;

  localparam int ANGLE_W = 32;   // Q4.27 signed
  localparam int SINE_W  = 32;   // Q1.30 signed
  localparam int TOL_W   = 31;   // Q1.30 unsigned
  localparam int FOLD_W  = 33;   // angle during folding, signed
  localparam int AX_W    = 29;   // |folded angle|, Q.27
  localparam int X2_W    = 31;   // x^2, Q.27
  localparam int MAG_W   = 33;   // term magnitude, Q.30
  localparam int PROD_W  = MAG_W + X2_W;
  localparam int SUM_W   = 36;   // series sum, Q.30 signed
  localparam int FRAC    = 27;
  localparam int DIVN_W  = PROD_W + 1 - FRAC;

  localparam logic signed [FOLD_W-1:0] PI_Q27     = 33'sd421657428;
  localparam logic signed [FOLD_W-1:0] TWO_PI_Q27 = 33'sd843314857;
  localparam logic [AX_W-1:0]          PI_MAG     = 29'd421657428;
  localparam logic signed [SUM_W-1:0]  ONE_Q30    = 36'sd1073741824;
  localparam logic [TOL_W-1:0]         TOL_RESET  = 31'd1074;

endpackage

### rtl/core/tsw_div.sv
// ----------------------------------------------------------------------------
// tsw_div
// Radix-16 restoring divider: unsigned dividend by a narrow divisor, four
// quotient bits per cycle.
// ----------------------------------------------------------------------------
module tsw_div #(
  parameter int NW = 38,
  parameter int MW = 11
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [MW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [NW-1:0] quotient
);

  localparam int STEPS = (NW + 3) / 4;
  localparam int PW    = STEPS * 4;
  localparam int CW    = $clog2(STEPS + 1);

  logic [PW-1:0] quo;
  logic [PW-1:0] quo_next;
  logic [MW-1:0] rem;
  logic [MW-1:0] rem_next;
  logic [MW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [MW:0]   t;
  logic [MW-1:0] r;
  logic [3:0]    bits;

  always_comb begin
    r    = rem;
    t    = '0;
    bits = '0;
    for (int i = 0; i < 4; i++) begin
      t = {r, quo[PW-1-i]};
      if (t >= {1'b0, dvs}) begin
        t = t - {1'b0, dvs};
        bits[3-i] = 1'b1;
      end
      r = t[MW-1:0];
    end
    rem_next = r;
    quo_next = {quo[PW-5:0], bits};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(STEPS);
      end else if (busy) begin
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= PW'(dividend);
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quotient = quo[NW-1:0];

endmodule

### rtl/core/taylor_sine_with_tolerance_core.sv
// ----------------------------------------------------------------------------
// taylor_sine_with_tolerance_core
// Folds a Q4.27 angle into [-pi, pi] and sums the sine Maclaurin series
// until a term falls to the tolerance or MAX_TERMS terms are summed; Q1.30 saturated result.
//
//   channel  signals                    payload
//   input    in_valid / in_ready        angle (Q4.27)
//   output   out_valid / out_ready      sine (Q1.30)
//   config   cfg_we                     cfg_data (tolerance, Q1.30)
//
// The sequencer folds the angle (at most 3 folds), squares it and then adds
// series terms, at most MAX_TERMS of them, and passes through idle before the
// next transfer. Each term after the first costs one pass of the shared
// multiplier and 10 steps of the radix-16 divider.
// Reset returns the tolerance to 1074 and empties the sequencer.
// in_ready is high only while the sequencer is idle; a result waiting on
// out_ready stalls the sequencer at its last step only.
// ----------------------------------------------------------------------------
module taylor_sine_with_tolerance_core
  import tsw_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [ANGLE_W-1:0] angle,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [SINE_W-1:0]  sine,
  input  logic                      cfg_we,
  input  logic [TOL_W-1:0]          cfg_data
);

  localparam int MW = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);
  localparam int NT = $clog2(MAX_TERMS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_FOLD  = 4'd1;
  localparam logic [3:0] S_SQR   = 4'd2;
  localparam logic [3:0] S_X2    = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_MUL   = 4'd5;
  localparam logic [3:0] S_DIVS  = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]               state;
  logic [3:0]               state_next;
  logic [TOL_W-1:0]         tol;
  logic signed [FOLD_W-1:0] a;
  logic [FOLD_W-1:0]        a_abs;
  logic [AX_W-1:0]          ax;
  logic [X2_W-1:0]          x2;
  logic [MAG_W-1:0]         mag;
  logic                     neg;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  term;
  logic signed [SUM_W-1:0]  sat;
  logic [NT-1:0]            n;
  logic [MW-1:0]            m;
  logic [MW-1:0]            inc;
  logic [MAG_W-1:0]         mul_a;
  logic [X2_W-1:0]          mul_b;
  logic [PROD_W-1:0]        prod;
  logic [PROD_W:0]          x2_round;
  logic [PROD_W:0]          div_round;
  logic                     div_start;
  logic                     div_busy;
  logic                     div_done;
  logic [DIVN_W-1:0]        div_q;
  logic                     more;
  logic                     can_load;

  assign in_ready  = (state == S_IDLE);
  assign a_abs     = a[FOLD_W-1] ? FOLD_W'(-a) : FOLD_W'(a);
  assign term      = neg ? -$signed(SUM_W'(mag)) : $signed(SUM_W'(mag));
  assign more      = (mag > {2'b00, tol});
  assign can_load  = !out_valid || out_ready;
  assign div_start = (state == S_DIVS);
  assign x2_round  = {1'b0, prod} + ((PROD_W + 1)'(1) << (FRAC - 1));
  assign div_round = {1'b0, prod} + ((PROD_W + 1)'(m) << (FRAC - 1));

  always_comb begin
    if (sum > ONE_Q30) begin
      sat = ONE_Q30;
    end else if (sum < -ONE_Q30) begin
      sat = -ONE_Q30;
    end else begin
      sat = sum;
    end
  end

  always_comb begin
    if (state == S_SQR) begin
      mul_a = MAG_W'(ax);
      mul_b = X2_W'(ax);
    end else begin
      mul_a = mag;
      mul_b = x2;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_valid) state_next = S_FOLD;
      S_FOLD:  if (!(a > PI_Q27) && !(a < -PI_Q27)) state_next = S_SQR;
      S_SQR:   state_next = S_X2;
      S_X2:    state_next = S_CHECK;
      S_CHECK: begin
        if (more && n != NT'(MAX_TERMS - 1)) begin
          state_next = S_MUL;
        end else begin
          state_next = S_FIN;
        end
      end
      S_MUL:   state_next = S_DIVS;
      S_DIVS:  state_next = S_DIVW;
      S_DIVW:  if (div_done) state_next = S_CHECK;
      S_FIN:   if (can_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      tol       <= TOL_RESET;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) tol <= cfg_data;
      if (state == S_FIN && can_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) a <= FOLD_W'(angle);
      end
      S_FOLD: begin
        if (a > PI_Q27) begin
          a <= a - TWO_PI_Q27;
        end else if (a < -PI_Q27) begin
          a <= a + TWO_PI_Q27;
        end else begin
          ax  <= a_abs[AX_W-1:0];
          neg <= a[FOLD_W-1];
        end
      end
      S_SQR: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      S_X2: begin
        x2  <= x2_round[FRAC +: X2_W];
        mag <= MAG_W'({ax, 3'b000});
        sum <= '0;
        n   <= '0;
        m   <= MW'(6);
        inc <= MW'(14);
      end
      S_CHECK: begin
        if (more) sum <= sum + term;
      end
      S_MUL: begin
        prod <= PROD_W'(mul_a) * PROD_W'(mul_b);
      end
      S_DIVW: begin
        if (div_done) begin
          mag <= div_q[MAG_W-1:0];
          neg <= !neg;
          n   <= n + NT'(1);
          m   <= m + inc;
          inc <= inc + MW'(8);
        end
      end
      S_FIN: begin
        if (can_load) sine <= sat[SINE_W-1:0];
      end
      default: begin
      end
    endcase
  end

  tsw_div #(
    .NW(DIVN_W),
    .MW(MW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_round[PROD_W:FRAC]),
    .divisor  (m),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  a_sine_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (sine <= 32'sd1073741824 && sine >= -32'sd1073741824))
    else $error("sine outside saturation range");

  a_fold_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_SQR) |-> (ax <= PI_MAG))
    else $error("folded angle above pi");

  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    (div_done || div_busy) |-> (state == S_DIVW))
    else $error("divider active outside wait state");

  a_one_item: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transfer taken while busy");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking regression for taylor_sine_with_tolerance_core.
// Angles go in over a valid/ready channel and each is matched against a
// series predictor that folds the angle and sums sine terms in fixed point
// under the current tolerance. The run uses directed edge angles, a few
// tolerance extremes, a long output stall and random angles under three
// idling mixes. Results are checked in order as they transfer out.
// ----------------------------------------------------------------------------
module testbench
  import tsw_pkg::*;
();

  localparam int TERM_LIMIT = 16;
  localparam int SEGMENT_ANGLES = 50;
  localparam int DRAIN_CYCLES = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ANGLE_W-1:0] angle = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [SINE_W-1:0] sine;
  logic cfg_we = 1'b0;
  logic [TOL_W-1:0] cfg_data = '0;

  logic signed [SINE_W-1:0] expected_sines[$];
  logic [TOL_W-1:0] tol_now = TOL_RESET;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  int angles_sent = 0;
  int directed_angles = 0;
  int sines_checked = 0;
  int tol_writes = 0;
  int errors = 0;

  taylor_sine_with_tolerance_core #(
    .MAX_TERMS(TERM_LIMIT)
  ) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .angle(angle),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .sine(sine),
    .cfg_we(cfg_we),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // Fold into [-pi, pi], then sum terms until one drops to the tolerance.
  function automatic logic signed [SINE_W-1:0] series_sine(
    input logic signed [ANGLE_W-1:0] ang,
    input logic [TOL_W-1:0] tol
  );
    longint folded;
    logic neg;
    longint unsigned ax;
    longint unsigned x2;
    longint unsigned mag;
    longint unsigned den;
    longint unsigned k;
    longint acc;
    folded = ang;
    while (folded > PI_Q27) folded -= TWO_PI_Q27;
    while (folded < -PI_Q27) folded += TWO_PI_Q27;
    neg = folded < 0;
    ax = neg ? longint'(-folded) : longint'(folded);
    x2 = (ax * ax + (64'd1 << 26)) >> 27;
    mag = ax * 8;
    acc = 0;
    for (int n = 0; n < TERM_LIMIT && mag > longint'(tol); n++) begin
      if (neg) acc = acc - longint'(mag);
      else acc = acc + longint'(mag);
      k = longint'(n) + 1;
      den = ((2 * k + 1) * (2 * k)) << 27;
      mag = (mag * x2 + den / 2) / den;
      neg = !neg;
    end
    if (acc > ONE_Q30) acc = ONE_Q30;
    if (acc < -ONE_Q30) acc = -ONE_Q30;
    return acc[SINE_W-1:0];
  endfunction

  function automatic logic signed [ANGLE_W-1:0] rand_angle();
    int v;
    case ($urandom_range(3))
      0: v = int'($urandom);
      1: v = int'($urandom_range(843314856)) - 421657428;
      2: begin
        v = int'($urandom_range(int'(tol_now >> 3) + 4));
        if ($urandom_range(1)) v = -v;
      end
      default: begin
        v = 421657428 * ($urandom_range(1) ? 3 : 1) + int'($urandom_range(8)) - 4;
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  // One transfer on the input side; the expectation is queued on acceptance.
  task automatic send_angle(input logic signed [ANGLE_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    angle <= v;
    do @(posedge clk); while (!in_ready);
    expected_sines.push_back(series_sine(v, tol_now));
    angles_sent++;
  endtask

  task automatic drain_sines();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_sines.size() != 0);
  endtask

  task automatic set_tolerance(input logic [TOL_W-1:0] v);
    drain_sines();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_now = v;
    tol_writes++;
  endtask

  task automatic test_default_tolerance();
    send_angle(134);
    send_angle(135);
    send_angle(-134);
    send_angle(-135);
  endtask

  task automatic test_angle_folding();
    send_angle(0);
    send_angle(32'sh7FFFFFFF);
    send_angle(32'sh80000000);
    send_angle(421657428);
    send_angle(-421657428);
    send_angle(421657429);
    send_angle(-421657429);
    send_angle(843314857);
    send_angle(-843314857);
    send_angle(1);
    send_angle(-1);
  endtask

  task automatic test_saturation();
    set_tolerance(31'd1);
    send_angle(210828714);
    send_angle(-210828714);
    send_angle(210828715);
    send_angle(-632486142);
  endtask

  task automatic test_tolerance_extremes();
    set_tolerance(31'd0);
    send_angle(421657427);
    send_angle(-123456789);
    set_tolerance(31'd1073741824);
    send_angle(134217728);
    send_angle(-134217729);
    set_tolerance(31'h7FFFFFFF);
    send_angle(421657428);
  endtask

  task automatic test_output_stall();
    set_tolerance(TOL_RESET);
    send_idle_pct = 0;
    hold_req = 400;
    repeat (6) send_angle(rand_angle());
    drain_sines();
  endtask

  task automatic test_random_angles();
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 16 : (p == 1) ? 62 : 0;
      recv_idle_pct = (p == 0) ? 62 : (p == 1) ? 16 : 0;
      for (int s = 0; s < 3; s++) begin
        case (s)
          0: set_tolerance(TOL_W'($urandom_range(4096, 1)));
          1: set_tolerance(TOL_W'($urandom_range(1 << 20, 1)));
          default: set_tolerance(TOL_W'($urandom & 32'h7FFFFFFF));
        endcase
        repeat (SEGMENT_ANGLES) send_angle(rand_angle());
      end
    end
    drain_sines();
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      hold_left = 0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_sines.size() == 0) begin
        $display("%0t: unexpected sine transfer, actual %0d", $time, sine);
        errors++;
      end else begin
        if (sine !== expected_sines[0]) begin
          $display("%0t: sine mismatch, expected %0d actual %0d",
                   $time, expected_sines[0], sine);
          errors++;
        end
        void'(expected_sines.pop_front());
        sines_checked++;
      end
    end
  end

  initial begin
    #10_000_000;
    $display("taylor_sine_with_tolerance_core regression: fail");
    $finish;
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    send_idle_pct = 16;
    recv_idle_pct = 62;
    test_default_tolerance();
    test_angle_folding();
    test_saturation();
    test_tolerance_extremes();
    directed_angles = angles_sent;
    test_output_stall();
    test_random_angles();
    drain_sines();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("angles sent %0d (%0d directed), sines checked %0d, tolerance writes %0d",
             angles_sent, directed_angles, sines_checked, tol_writes);
    $display("covered folding edges, saturation, tolerance extremes, output stall");
    if (errors == 0) begin
      $display("taylor_sine_with_tolerance_core regression: pass");
    end else begin
      $display("taylor_sine_with_tolerance_core regression: fail");
    end
    $finish;
  end

endmodule
